// File: sv/rws_pkg.sv
// ----------------------------------------------------------------------------
// Weighted reservoir selector package
// Shared widths, reset constants, register indexes and the generator step.
// ----------------------------------------------------------------------------
package rws_pkg;

   localparam int unsigned ID_W         = 16;
   localparam int unsigned WEIGHT_W     = 16;
   localparam int unsigned VAL_W        = 31;
   localparam int unsigned RNG_W        = 32;
   localparam int unsigned CSR_INDEX_W  = 1;
   localparam int unsigned CSR_DATA_W   = 32;

   localparam int unsigned ID_BITS_DEF  = 16;
   localparam int unsigned DRAW_MAX_DEF = 32'd2147483647;

   localparam logic [ID_W-1:0]  INVALID_AT_RESET = 16'hFFFF;
   localparam logic [RNG_W-1:0] SEED_AT_RESET    = 32'h92D6_8CA2;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_OFFER = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_INVALID_ID  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANDOM_SEED = 1'b1;

   typedef struct packed {
      logic             load;
      logic             step;
      logic [RNG_W-1:0] value;
   } rng_cmd_type;

   function automatic logic [RNG_W-1:0] xorshift_step(input logic [RNG_W-1:0] w);
      logic [RNG_W-1:0] a;
      logic [RNG_W-1:0] b;
      a = w ^ (w << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

endpackage

// File: sv/weighted_reservoir_selector.sv
// ----------------------------------------------------------------------------
// Weighted reservoir selector
// One-pick weighted sampler with a shared iterative remainder unit.
// Start items and refused or zero-weight offers go from evaluation straight to
// the finish state. A drawing offer takes two passes through the remainder
// unit: one for the draw bound, one for a roll below it; others are redrawn.
// Throughput: one item at a time; the next item is taken once the last result
// sits in the output register. Synchronous reset skips the data registers.
// ----------------------------------------------------------------------------
module weighted_reservoir_selector
   import rws_pkg::*;
#(
   parameter int unsigned ID_BITS  = ID_BITS_DEF,
   parameter int unsigned DRAW_MAX = DRAW_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,  // item_id, item_weight
   input  logic                   req_tuser,  // action
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [47:0]            rsp_tdata,  // chosen_id, weight_total, zero fill
   output logic [1:0]             rsp_tuser,  // replaced, overflow
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam logic [ID_W-1:0] ID_MASK =
      (ID_BITS >= ID_W) ? '1 : ID_W'((64'd1 << ID_BITS) - 64'd1);
   localparam logic [VAL_W-1:0] DRAW_LIMIT = VAL_W'(DRAW_MAX);
   localparam int unsigned ROLL_BITS = $clog2(64'(DRAW_MAX) + 64'd1);
   localparam logic [VAL_W-1:0] ROLL_MASK = VAL_W'((64'd1 << ROLL_BITS) - 64'd1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EVAL   = 6'b000010,
      ST_BOUND  = 6'b000100,
      ST_DRAW   = 6'b001000,
      ST_REDUCE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [ID_W-1:0]   invalid_ff, invalid_in;
   logic [RNG_W-1:0]  seed_ff, seed_in;
   logic [ID_W-1:0]   pick_ff, pick_in;
   logic [VAL_W-1:0]  total_ff, total_in;
   logic              action_ff, action_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [VAL_W-1:0]  new_total_ff, new_total_in;
   logic [VAL_W-1:0]  range_ff, range_in;
   logic [VAL_W-1:0]  bound_ff, bound_in;
   logic              replaced_ff, replaced_in;
   logic              overflow_ff, overflow_in;
   logic              out_valid_ff, out_valid_in;
   logic [ID_W-1:0]   out_id_ff, out_id_in;
   logic [VAL_W-1:0]  out_total_ff, out_total_in;
   logic              out_replaced_ff, out_replaced_in;
   logic              out_overflow_ff, out_overflow_in;

   logic              mod_start;
   logic [VAL_W-1:0]  mod_dividend;
   logic              mod_done;
   logic [VAL_W-1:0]  mod_rem;
   rng_cmd_type       rng_cmd;
   logic [RNG_W-1:0]  rng_word;
   logic [RNG_W-1:0]  rng_next;
   logic [VAL_W-1:0]  roll;
   logic [VAL_W:0]    sum;
   logic              req_fire;
   logic              slot_free;

   rws_mod_unit #(
      .WIDTH (VAL_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (range_in),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   rws_rng u_rng (
      .clock     (clock),
      .reset     (reset),
      .cmd       (rng_cmd),
      .word      (rng_word),
      .next_word (rng_next)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign slot_free  = !out_valid_ff || rsp_tready;
   assign roll       = rng_next[VAL_W:1] & ROLL_MASK;
   assign sum        = {1'b0, total_ff} + (VAL_W + 1)'(weight_ff);

   always_comb begin
      invalid_in = invalid_ff;
      seed_in    = seed_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INVALID_ID:  invalid_in = csr_data[ID_W-1:0];
            CSR_RANDOM_SEED: seed_in    = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      pick_in         = pick_ff;
      total_in        = total_ff;
      action_in       = action_ff;
      id_in           = id_ff;
      weight_in       = weight_ff;
      new_total_in    = new_total_ff;
      range_in        = range_ff;
      bound_in        = bound_ff;
      replaced_in     = replaced_ff;
      overflow_in     = overflow_ff;
      out_valid_in    = out_valid_ff && !rsp_tready;
      out_id_in       = out_id_ff;
      out_total_in    = out_total_ff;
      out_replaced_in = out_replaced_ff;
      out_overflow_in = out_overflow_ff;
      mod_start       = 1'b0;
      mod_dividend    = DRAW_LIMIT;
      rng_cmd         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               action_in = req_tuser;
               id_in     = req_tdata[ID_W-1:0] & ID_MASK;
               weight_in = req_tdata[ID_W +: WEIGHT_W];
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            replaced_in = 1'b0;
            overflow_in = 1'b0;
            state_in    = ST_FINISH;
            if (action_ff == ACTION_START) begin
               pick_in       = invalid_ff & ID_MASK;
               total_in      = '0;
               rng_cmd.load  = 1'b1;
               rng_cmd.value = (seed_ff != '0) ? seed_ff : SEED_AT_RESET;
            end else if (weight_ff != '0) begin
               if (sum >= {1'b0, DRAW_LIMIT}) begin
                  overflow_in = 1'b1;
               end else begin
                  new_total_in = sum[VAL_W-1:0];
                  range_in     = sum[VAL_W-1:0] + VAL_W'(1);
                  if (rng_word == '0) begin
                     rng_cmd.load  = 1'b1;
                     rng_cmd.value = SEED_AT_RESET;
                  end
                  state_in = ST_BOUND;
               end
            end
         end
         ST_BOUND: begin
            if (mod_done) begin
               bound_in = DRAW_LIMIT - mod_rem;
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            rng_cmd.step = 1'b1;
            if (roll < bound_ff) begin
               mod_start    = 1'b1;
               mod_dividend = roll;
               state_in     = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mod_done) begin
               if (mod_rem > total_ff) begin
                  pick_in     = id_ff;
                  replaced_in = 1'b1;
               end
               total_in = new_total_ff;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               out_valid_in    = 1'b1;
               out_id_in       = pick_ff;
               out_total_in    = total_ff;
               out_replaced_in = replaced_ff;
               out_overflow_in = overflow_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (state_ff == ST_EVAL && state_in == ST_BOUND) begin
         mod_start    = 1'b1;
         mod_dividend = DRAW_LIMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         invalid_ff   <= INVALID_AT_RESET;
         seed_ff      <= SEED_AT_RESET;
         pick_ff      <= INVALID_AT_RESET & ID_MASK;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         invalid_ff   <= invalid_in;
         seed_ff      <= seed_in;
         pick_ff      <= pick_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
      action_ff       <= action_in;
      id_ff           <= id_in;
      weight_ff       <= weight_in;
      new_total_ff    <= new_total_in;
      range_ff        <= range_in;
      bound_ff        <= bound_in;
      replaced_ff     <= replaced_in;
      overflow_ff     <= overflow_in;
      out_id_ff       <= out_id_in;
      out_total_ff    <= out_total_in;
      out_replaced_ff <= out_replaced_in;
      out_overflow_ff <= out_overflow_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_total_ff, out_id_ff};
   assign rsp_tuser  = {out_overflow_ff, out_replaced_ff};

endmodule

// File: sv/rws_mod_unit.sv
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring division, one quotient bit per cycle, giving dividend mod divisor.
// ----------------------------------------------------------------------------
module rws_mod_unit
   import rws_pkg::*;
#(
   parameter int unsigned WIDTH = VAL_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] remainder
);

   localparam int unsigned CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [WIDTH:0]   trial;

   assign trial = {rem_ff, dvd_ff[WIDTH-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH - 1);
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = WIDTH'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[WIDTH-1:0];
         end
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: sv/rws_rng.sv
// ----------------------------------------------------------------------------
// Xorshift generator
// Holds the 32-bit generator word; loads a seed or steps on command.
// ----------------------------------------------------------------------------
module rws_rng
   import rws_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  rng_cmd_type      cmd,
   output logic [RNG_W-1:0] word,
   output logic [RNG_W-1:0] next_word
);

   logic [RNG_W-1:0] word_ff, word_in;

   assign next_word = xorshift_step(word_ff);

   always_comb begin
      word_in = word_ff;
      if (cmd.load) begin
         word_in = cmd.value;
      end else if (cmd.step) begin
         word_in = next_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= SEED_AT_RESET;
      end else begin
         word_ff <= word_in;
      end
   end

   assign word = word_ff;

endmodule
